// ----- hw/rtl/xpfec_pkg.sv -----
// ----------------------------------------------------------------------------
// xpfec_pkg
// Shared types and codes of the single-parity XOR FEC codec: field widths,
// configuration register indexes, result kinds and the beat payloads.
// ----------------------------------------------------------------------------
`default_nettype none

package xpfec_pkg;

  // Fixed field widths.
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned ID_W       = 13;
  localparam int unsigned LEN_W      = 12;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 12;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] CFG_MODE          = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SYMBOL_LENGTH = 4'd1;

  // Mode codes (encode after reset) and the symbol length after reset.
  localparam logic             MODE_ENCODE         = 1'b0;
  localparam logic             MODE_DECODE         = 1'b1;
  localparam logic [LEN_W-1:0] SYMBOL_LENGTH_RESET = 12'd1024;

  // Input actions.
  localparam logic ACT_DATA = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // Kind of an emitted byte.
  typedef enum logic [1:0] {
    KIND_SOURCE    = 2'd0,
    KIND_PARITY    = 2'd1,
    KIND_RECOVERED = 2'd2,
    KIND_NONE      = 2'd3
  } kind_e;

  // Input beat.
  typedef struct packed {
    logic              action;
    logic [BYTE_W-1:0] data_byte;
    logic [ID_W-1:0]   symbol_id;
    logic [ID_W-1:0]   block_symbols;
    logic              end_of_symbol;
    logic              end_of_block;
  } in_item_t;

  // Output beat.
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic [ID_W-1:0]   out_symbol_id;
    kind_e             kind;
    logic              last;
  } out_item_t;

endpackage

`default_nettype wire

// ----- hw/rtl/xpfec_in_if.sv -----
// ----------------------------------------------------------------------------
// xpfec_in_if
// Valid/ready channel that carries one input beat of the codec.
// ----------------------------------------------------------------------------
`default_nettype none

interface xpfec_in_if;
  import xpfec_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/xpfec_out_if.sv -----
// ----------------------------------------------------------------------------
// xpfec_out_if
// Valid/ready channel that carries one result beat of the codec.
// ----------------------------------------------------------------------------
`default_nettype none

interface xpfec_out_if;
  import xpfec_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/xpfec_cfg_if.sv -----
// ----------------------------------------------------------------------------
// xpfec_cfg_if
// Register write channel: register index and write data with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface xpfec_cfg_if;
  import xpfec_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output addr, output wdata, input ready);
  modport sink   (input valid, input addr, input wdata, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/xpfec_ram.sv -----
// ----------------------------------------------------------------------------
// xpfec_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module xpfec_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/xor_parity_fec_codec.sv -----
// A result beat passes the memory stage and the output FIFO before it is
// offered. Throughput: one input beat per cycle while the FIFO has room;
// the parity store does one read-modify-write per beat, with the just-written
// byte forwarded. Results queue in a four-entry output FIFO, so input keeps
// flowing while a result waits. After reset all MAX_SYMBOL_BYTES store entries
// (2048 by default) are cleared; input is held off, register writes are taken.
// ----------------------------------------------------------------------------
// xor_parity_fec_codec
// Single-parity XOR erasure codec: encodes a source block into a parity
// symbol, or recovers one missing symbol from the received units.
// ----------------------------------------------------------------------------
`default_nettype none

module xor_parity_fec_codec #(
  parameter int unsigned MAX_SYMBOL_BYTES   = 2048,
  parameter int unsigned MAX_SOURCE_SYMBOLS = 4096
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  xpfec_cfg_if.sink  cfg_if,
  xpfec_in_if.sink   in_if,
  xpfec_out_if.source out_if
);
  import xpfec_pkg::*;

  localparam int unsigned POS_W = (MAX_SYMBOL_BYTES > 1) ? $clog2(MAX_SYMBOL_BYTES) : 1;
  localparam int unsigned CMP_W = (POS_W + 1 > LEN_W) ? POS_W + 1 : LEN_W;
  localparam int unsigned CNT_W = $clog2(MAX_SOURCE_SYMBOLS + 1);
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = 2;
  localparam int unsigned OCC_W      = 3;

  // Configuration registers.
  logic             mode_q, mode_d;
  logic [LEN_W-1:0] sym_len_q, sym_len_d;

  // Codec state.
  logic [POS_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] sym_cnt_q, sym_cnt_d;
  logic [ID_W-1:0]  exp_id_q, exp_id_d;
  logic [ID_W-1:0]  miss_id_q, miss_id_d;
  logic             gap_found_q, gap_found_d;
  logic             parity_seen_q, parity_seen_d;
  logic             draining_q, draining_d;

  // Store clearing pass after reset.
  logic             clearing_q;
  logic [POS_W-1:0] clr_addr_q;

  // Memory stage.
  logic              s1_valid_q, s1_valid_d;
  logic              s1_xor_q, s1_xor_d;
  logic [POS_W-1:0]  s1_addr_q;
  logic [BYTE_W-1:0] s1_data_q, s1_data_d;
  logic              s1_res_q, s1_res_d;
  logic              s1_from_mem_q, s1_from_mem_d;
  logic [ID_W-1:0]   s1_id_q, s1_id_d;
  kind_e             s1_kind_q, s1_kind_d;
  logic              s1_last_q, s1_last_d;

  // Write forwarding.
  logic              fwd_valid_q;
  logic [POS_W-1:0]  fwd_addr_q;
  logic [BYTE_W-1:0] fwd_data_q;

  // Output FIFO.
  out_item_t        fifo_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [OCC_W-1:0] fifo_cnt_q;
  logic [OCC_W-1:0] occupancy;

  logic              in_acc, out_acc, push;
  in_item_t          item;
  logic [CMP_W-1:0]  eff_len, pos_inc;
  logic              at_last;
  logic              unit_end, enc_last;
  logic [BYTE_W-1:0] ram_rdata, old_byte, ram_wdata;
  logic              ram_we;
  logic [POS_W-1:0]  ram_waddr;
  out_item_t         push_item;

  assign item    = in_if.payload;
  assign in_acc  = in_if.valid & in_if.ready;
  assign out_acc = out_if.valid & out_if.ready;

  // Register writes are always taken.
  assign cfg_if.ready = 1'b1;

  always_comb begin
    mode_d    = mode_q;
    sym_len_d = sym_len_q;
    if (cfg_if.valid) begin
      case (cfg_if.addr)
        CFG_MODE:          mode_d    = cfg_if.wdata[0];
        CFG_SYMBOL_LENGTH: sym_len_d = cfg_if.wdata[LEN_W-1:0];
        default:           ;
      endcase
    end
  end

  // Effective symbol length: zero acts as one, clipped to the store size.
  always_comb begin
    if (sym_len_q == '0) begin
      eff_len = CMP_W'(1);
    end else if (CMP_W'(sym_len_q) > CMP_W'(MAX_SYMBOL_BYTES)) begin
      eff_len = CMP_W'(MAX_SYMBOL_BYTES);
    end else begin
      eff_len = CMP_W'(sym_len_q);
    end
  end

  assign pos_inc  = CMP_W'(pos_q) + CMP_W'(1);
  assign at_last  = (pos_inc >= eff_len);
  assign unit_end = item.end_of_symbol | item.end_of_block;
  assign enc_last = item.end_of_block | at_last;

  // Accept stage: state update and memory stage setup for one beat.
  always_comb begin
    pos_d         = pos_q;
    sym_cnt_d     = sym_cnt_q;
    exp_id_d      = exp_id_q;
    miss_id_d     = miss_id_q;
    gap_found_d   = gap_found_q;
    parity_seen_d = parity_seen_q;
    draining_d    = draining_q;
    s1_valid_d    = 1'b0;
    s1_xor_d      = 1'b0;
    s1_data_d     = item.data_byte;
    s1_res_d      = 1'b0;
    s1_from_mem_d = 1'b0;
    s1_id_d       = ID_W'(sym_cnt_q);
    s1_kind_d     = KIND_SOURCE;
    s1_last_d     = 1'b0;
    if (in_acc) begin
      if (item.action == ACT_READ) begin
        if (draining_q) begin
          // Drain one byte of the store and clear it.
          s1_valid_d = 1'b1;
          s1_res_d   = 1'b1;
          s1_last_d  = at_last;
          if (at_last) begin
            pos_d      = '0;
            draining_d = 1'b0;
          end else begin
            pos_d = pos_q + POS_W'(1);
          end
          if (mode_q == MODE_ENCODE) begin
            s1_kind_d     = KIND_PARITY;
            s1_from_mem_d = 1'b1;
            if (at_last) begin
              sym_cnt_d = '0;
            end
          end else begin
            if (gap_found_q && parity_seen_q) begin
              s1_kind_d     = KIND_RECOVERED;
              s1_id_d       = miss_id_q;
              s1_from_mem_d = 1'b1;
            end else begin
              s1_kind_d = KIND_NONE;
              s1_id_d   = '0;
              s1_data_d = '0;
            end
            if (at_last) begin
              exp_id_d      = '0;
              miss_id_d     = '0;
              gap_found_d   = 1'b0;
              parity_seen_d = 1'b0;
            end
          end
        end
      end else if (!draining_q) begin
        s1_valid_d = 1'b1;
        s1_xor_d   = 1'b1;
        if (mode_q == MODE_ENCODE) begin
          // Pass the source byte through and fold it into the parity.
          s1_res_d  = 1'b1;
          s1_kind_d = KIND_SOURCE;
          s1_last_d = enc_last;
          if (enc_last) begin
            pos_d = '0;
            if (sym_cnt_q < CNT_W'(MAX_SOURCE_SYMBOLS)) begin
              sym_cnt_d = sym_cnt_q + CNT_W'(1);
            end
          end else begin
            pos_d = pos_q + POS_W'(1);
          end
          if (item.end_of_block) begin
            draining_d = 1'b1;
          end
        end else begin
          // Accumulate a received byte and track the unit ids.
          if (unit_end || at_last) begin
            pos_d = '0;
          end else begin
            pos_d = pos_q + POS_W'(1);
          end
          if (unit_end) begin
            if (!gap_found_q && (item.symbol_id != exp_id_q)) begin
              gap_found_d = 1'b1;
              miss_id_d   = exp_id_q;
            end else begin
              exp_id_d = item.symbol_id + ID_W'(1);
            end
            parity_seen_d = (item.symbol_id == item.block_symbols);
          end
          if (item.end_of_block) begin
            draining_d = 1'b1;
            pos_d      = '0;
          end
        end
      end
    end
  end

  // Memory stage: merge the stored byte with the last write to the same spot.
  assign old_byte  = (fwd_valid_q && (fwd_addr_q == s1_addr_q)) ? fwd_data_q : ram_rdata;
  assign ram_wdata = (s1_xor_q && !clearing_q) ? (old_byte ^ s1_data_q) : '0;
  assign ram_we    = clearing_q | s1_valid_q;
  assign ram_waddr = clearing_q ? clr_addr_q : s1_addr_q;

  xpfec_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_SYMBOL_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_acc),
    .raddr_i (pos_q),
    .rdata_o (ram_rdata)
  );

  // Result beat leaving the memory stage.
  assign push = s1_valid_q & s1_res_q;
  always_comb begin
    push_item.out_byte      = s1_from_mem_q ? old_byte : s1_data_q;
    push_item.out_symbol_id = s1_id_q;
    push_item.kind          = s1_kind_q;
    push_item.last          = s1_last_q;
  end

  // Take input only while every beat in flight is sure of a FIFO slot.
  assign occupancy   = fifo_cnt_q + OCC_W'(s1_valid_q);
  assign in_if.ready = !clearing_q && (occupancy < OCC_W'(FIFO_DEPTH));

  assign out_if.valid   = (fifo_cnt_q != '0);
  assign out_if.payload = fifo_q[rd_ptr_q];

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_ENCODE;
      sym_len_q     <= SYMBOL_LENGTH_RESET;
      pos_q         <= '0;
      sym_cnt_q     <= '0;
      exp_id_q      <= '0;
      miss_id_q     <= '0;
      gap_found_q   <= 1'b0;
      parity_seen_q <= 1'b0;
      draining_q    <= 1'b0;
      clearing_q    <= 1'b1;
      clr_addr_q    <= '0;
      s1_valid_q    <= 1'b0;
      fwd_valid_q   <= 1'b0;
      wr_ptr_q      <= '0;
      rd_ptr_q      <= '0;
      fifo_cnt_q    <= '0;
    end else begin
      mode_q        <= mode_d;
      sym_len_q     <= sym_len_d;
      pos_q         <= pos_d;
      sym_cnt_q     <= sym_cnt_d;
      exp_id_q      <= exp_id_d;
      miss_id_q     <= miss_id_d;
      gap_found_q   <= gap_found_d;
      parity_seen_q <= parity_seen_d;
      draining_q    <= draining_d;
      if (clearing_q) begin
        if (clr_addr_q == POS_W'(MAX_SYMBOL_BYTES - 1)) begin
          clearing_q <= 1'b0;
        end
        clr_addr_q <= clr_addr_q + POS_W'(1);
      end
      s1_valid_q  <= s1_valid_d;
      fwd_valid_q <= s1_valid_q;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (out_acc) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      fifo_cnt_q <= fifo_cnt_q + OCC_W'(push) - OCC_W'(out_acc);
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    s1_xor_q      <= s1_xor_d;
    s1_addr_q     <= pos_q;
    s1_data_q     <= s1_data_d;
    s1_res_q      <= s1_res_d;
    s1_from_mem_q <= s1_from_mem_d;
    s1_id_q       <= s1_id_d;
    s1_kind_q     <= s1_kind_d;
    s1_last_q     <= s1_last_d;
    fwd_addr_q    <= s1_addr_q;
    fwd_data_q    <= ram_wdata;
    if (push) begin
      fifo_q[wr_ptr_q] <= push_item;
    end
  end

  // The FIFO and the memory stage never hold more beats than there are slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occupancy <= OCC_W'(FIFO_DEPTH))
    else $error("output FIFO overcommitted");

  // The byte position always stays inside the store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(pos_q) < CMP_W'(MAX_SYMBOL_BYTES))
    else $error("byte position beyond store");

  // Every drain step produces a result beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_xor_q) |-> s1_res_q)
    else $error("drain step without result");

  // Finishing a decode drain leaves the gap tracking cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($fell(draining_q) && ($past(mode_q) == MODE_DECODE)) |-> (!gap_found_q && !parity_seen_q))
    else $error("gap tracking not cleared after recovery");

endmodule

`default_nettype wire
